FILE: hdl/byte_run_length_encoder_macros.svh
// Assertion macros for the byte run-length encoder.
`ifndef BYTE_RUN_LENGTH_ENCODER_MACROS_SVH
`define BYTE_RUN_LENGTH_ENCODER_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define BRLE_ASSERT_SAME(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("byte_run_length_encoder: assertion failed");

// Check a condition in the cycle after its trigger.
`define BRLE_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("byte_run_length_encoder: assertion failed");

`endif

FILE: hdl/brle_pkg.sv
// Types and constants for the byte run-length encoder.
package brle_pkg;

   localparam logic [7:0] RUN_LIMIT_RESET = 8'd255;
   localparam logic [7:0] RUN_LIMIT_FLOOR = 8'd2;
   localparam int         RESULT_SLOTS    = 4;

   typedef struct packed {
      logic [7:0]  byte_value;
      logic        is_count;
      logic [31:0] run_start;
      logic [31:0] run_total;
      logic        last;
   } result_type;

endpackage

FILE: hdl/brle_req_if.sv
// Input channel of the byte run-length encoder: one raw byte per word.
interface brle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_data;

   modport source (output valid, output data_byte, output end_of_data, input ready);
   modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

FILE: hdl/brle_rsp_if.sv
// Result channel of the byte run-length encoder: one count or literal byte per word.
interface brle_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_value;
   logic        is_count;
   logic [31:0] run_start;
   logic [31:0] run_total;
   logic        last;

   modport source (output valid, output byte_value, output is_count, output run_start,
                   output run_total, output last, input ready);
   modport sink (input valid, input byte_value, input is_count, input run_start,
                 input run_total, input last, output ready);
endinterface

FILE: hdl/byte_run_length_encoder.sv
// Byte run-length encoder: folds equal adjacent bytes into count and literal words.
//
// One input word is taken per cycle into an input register while that register is
// empty or its byte advances; the run logic then updates its state and loads zero
// to four result words into a four-entry result buffer. The result port drains that
// buffer one word per cycle while the receiver is ready, so the sustained rate is
// one byte per cycle while bytes extend a run or break it into a single word and the
// receiver is ready. A new byte waits in the input register while the buffer still
// holds more than its final word, as after a break that gives a count and a byte or
// a byte carrying the end marker. Positions count from 1 in each stream and wrap at
// 2**POSITION_WIDTH; run_start carries their low 32 bits.
`include "byte_run_length_encoder_macros.svh"

module byte_run_length_encoder
   import brle_pkg::*;
#(
   parameter int POSITION_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   brle_req_if.sink    req_chan,
   brle_rsp_if.source  rsp_chan
);

   localparam int COUNT_WIDTH = $clog2(RESULT_SLOTS + 1);

   logic [7:0]                max_run_ff;
   logic                      in_valid_ff;
   logic [7:0]                in_byte_ff;
   logic                      in_end_ff;
   logic [7:0]                held_byte_ff, held_byte_in;
   logic [7:0]                run_length_ff, run_length_in;
   logic                      holding_ff, holding_in;
   logic [POSITION_WIDTH-1:0] position_ff, position_in;
   logic [POSITION_WIDTH-1:0] run_start_ff, run_start_in;
   logic [31:0]               counted_ff, counted_in;
   result_type                slot_ff [RESULT_SLOTS];
   result_type                slot_in [RESULT_SLOTS];
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;

   logic                      take;
   logic                      advance;
   logic [7:0]                limit;
   logic                      extend;
   logic [POSITION_WIDTH-1:0] next_position;
   logic [7:0]                new_byte;
   logic [7:0]                new_length;
   logic [POSITION_WIDTH-1:0] new_start;
   logic [63:0]               old_start_wide;
   logic [63:0]               new_start_wide;
   logic                      old_count_v;
   logic                      old_byte_v;
   logic                      new_count_v;
   logic                      new_byte_v;
   logic [31:0]               total;
   result_type                cand [RESULT_SLOTS];
   logic                      cand_v [RESULT_SLOTS];
   result_type                packed_slot [RESULT_SLOTS];
   logic [COUNT_WIDTH-1:0]    packed_count;

   assign take    = rsp_chan.valid && rsp_chan.ready;
   assign advance = in_valid_ff &&
                    ((count_ff == '0) || ((count_ff == COUNT_WIDTH'(1)) && rsp_chan.ready));
   assign req_chan.ready = !in_valid_ff || advance;

   assign limit         = (max_run_ff < RUN_LIMIT_FLOOR) ? RUN_LIMIT_FLOOR : max_run_ff;
   assign extend        = holding_ff && (in_byte_ff == held_byte_ff) && (run_length_ff < limit);
   assign next_position = position_ff + POSITION_WIDTH'(1);
   assign new_byte      = extend ? held_byte_ff : in_byte_ff;
   assign new_length    = extend ? (run_length_ff + 8'd1) : 8'd1;
   assign new_start     = extend ? run_start_ff : next_position;

   assign old_start_wide = 64'(run_start_ff);
   assign new_start_wide = 64'(new_start);

   assign old_byte_v  = !extend && holding_ff;
   assign old_count_v = old_byte_v && (run_length_ff > 8'd1);
   assign new_byte_v  = in_end_ff;
   assign new_count_v = in_end_ff && (new_length > 8'd1);
   assign total       = counted_ff + 32'(old_count_v) + 32'(new_count_v);

   always_comb begin
      cand[0] = '{byte_value: run_length_ff, is_count: 1'b1,
                  run_start: old_start_wide[31:0], run_total: 32'd0, last: 1'b0};
      cand[1] = '{byte_value: held_byte_ff, is_count: 1'b0,
                  run_start: 32'd0, run_total: 32'd0, last: 1'b0};
      cand[2] = '{byte_value: new_length, is_count: 1'b1,
                  run_start: new_start_wide[31:0], run_total: 32'd0, last: 1'b0};
      cand[3] = '{byte_value: new_byte, is_count: 1'b0,
                  run_start: 32'd0, run_total: total, last: 1'b1};
      cand_v[0] = old_count_v;
      cand_v[1] = old_byte_v;
      cand_v[2] = new_count_v;
      cand_v[3] = new_byte_v;
   end

   // pack the valid candidates to the front of the buffer
   always_comb begin
      logic [COUNT_WIDTH-1:0] idx;
      idx = '0;
      for (int i = 0; i < RESULT_SLOTS; i++) begin
         packed_slot[i] = cand[i];
      end
      for (int i = 0; i < RESULT_SLOTS; i++) begin
         if (cand_v[i]) begin
            packed_slot[idx[COUNT_WIDTH-2:0]] = cand[i];
            idx = idx + COUNT_WIDTH'(1);
         end
      end
      packed_count = idx;
   end

   always_comb begin
      held_byte_in  = held_byte_ff;
      run_length_in = run_length_ff;
      holding_in    = holding_ff;
      position_in   = position_ff;
      run_start_in  = run_start_ff;
      counted_in    = counted_ff;
      count_in      = count_ff;
      for (int i = 0; i < RESULT_SLOTS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (advance) begin
         if (in_end_ff) begin
            held_byte_in  = 8'd0;
            run_length_in = 8'd0;
            holding_in    = 1'b0;
            position_in   = '0;
            run_start_in  = '0;
            counted_in    = 32'd0;
         end else begin
            held_byte_in  = new_byte;
            run_length_in = new_length;
            holding_in    = 1'b1;
            position_in   = next_position;
            run_start_in  = new_start;
            counted_in    = counted_ff + 32'(old_count_v);
         end
         count_in = packed_count;
         for (int i = 0; i < RESULT_SLOTS; i++) begin
            slot_in[i] = packed_slot[i];
         end
      end else if (take) begin
         count_in = count_ff - COUNT_WIDTH'(1);
         for (int i = 0; i < RESULT_SLOTS - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_run_ff    <= RUN_LIMIT_RESET;
         in_valid_ff   <= 1'b0;
         held_byte_ff  <= 8'd0;
         run_length_ff <= 8'd0;
         holding_ff    <= 1'b0;
         position_ff   <= '0;
         run_start_ff  <= '0;
         counted_ff    <= 32'd0;
         count_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            max_run_ff <= csr_wr_data;
         end
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         held_byte_ff  <= held_byte_in;
         run_length_ff <= run_length_in;
         holding_ff    <= holding_in;
         position_ff   <= position_in;
         run_start_ff  <= run_start_in;
         counted_ff    <= counted_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
         in_end_ff  <= req_chan.end_of_data;
      end
      for (int i = 0; i < RESULT_SLOTS; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign rsp_chan.valid      = (count_ff != '0);
   assign rsp_chan.byte_value = slot_ff[0].byte_value;
   assign rsp_chan.is_count   = slot_ff[0].is_count;
   assign rsp_chan.run_start  = slot_ff[0].run_start;
   assign rsp_chan.run_total  = slot_ff[0].run_total;
   assign rsp_chan.last       = slot_ff[0].last;

   `BRLE_ASSERT_SAME(a_count_range, 1'b1, count_ff <= COUNT_WIDTH'(RESULT_SLOTS))
   `BRLE_ASSERT_SAME(a_last_is_literal, rsp_chan.valid && rsp_chan.last, !rsp_chan.is_count)
   `BRLE_ASSERT_NEXT(a_end_clears_run, advance && in_end_ff, !holding_ff && (counted_ff == 32'd0))
   `BRLE_ASSERT_NEXT(a_end_gives_word, advance && in_end_ff, count_ff != '0)

endmodule
